[rtl/plrx_pkg.sv]
// package for the path loss / received power engine
// holds sizes, fixed-point types, model constants, the log2 rom and helper functions
// no dependencies
package plrx_pkg;

	// sizes
	localparam int LOG_TABLE_BITS = 8;
	localparam int DISTANCE_BITS  = 24;
	localparam int LOG_ROM_DEPTH  = 1 << LOG_TABLE_BITS;
	localparam int N_STAGES       = 10;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 2;

	localparam int LG2_W  = 21;   // unsigned log2, Q16
	localparam int LGP_W  = 50;   // log2 times a Q30 log base factor
	localparam int LG_W   = 21;   // signed log10 / ln terms, Q16
	localparam int PW_W   = 44;   // signed Q32 products
	localparam int RV_W   = 28;   // products rounded back to Q16
	localparam int ACC_W  = 32;   // loss and power sums

	typedef logic [LG2_W-1:0]        lg2_t;
	typedef logic [LGP_W-1:0]        lgp_t;
	typedef logic signed [LG_W-1:0]  lg_t;
	typedef logic signed [PW_W-1:0]  pw_t;
	typedef logic signed [RV_W-1:0]  rv_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// leading-one position and the table index behind it
	typedef struct packed {
		logic [4:0]                e;
		logic [LOG_TABLE_BITS-1:0] k;
	} lgix_t;

	typedef logic [15:0] lrom_t [LOG_ROM_DEPTH];

	// register map
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FREQUENCY,
		REG_TX_HEIGHT,
		REG_RX_HEIGHT,
		REG_ENVIRONMENT
	} reg_index_t;

	// terrain classes, the unused code counts as rural
	typedef enum logic [1:0] {
		ENV_URBAN,
		ENV_SUBURBAN,
		ENV_RURAL
	} env_t;

	localparam logic [15:0] FREQUENCY_RESET = 16'd2000;
	localparam logic [15:0] TX_HEIGHT_RESET = 16'd5000;
	localparam logic [15:0] RX_HEIGHT_RESET = 16'd300;

	// log base conversion factors, Q30
	localparam logic [29:0] LOG10_2_Q30 = 30'd323228497;
	localparam logic [29:0] LN_2_Q30    = 30'd744261118;

	// model constants, Q16
	localparam int Q16_ONE       = 65536;
	localparam int C_A0_URBAN    = 2372403;
	localparam int C_A1_URBAN    = 1979187;
	localparam int C_A0_SUBURBAN = 2831155;
	localparam int C_A1_SUBURBAN = 4517404;
	localparam int C_A0_RURAL    = 3011379;
	localparam int C_A1_RURAL    = 6592922;
	localparam int C_FREQ_LIN    = 2915697;
	localparam int C_FREQ_SQ     = 313262;
	localparam int C_CROSS       = 6554;
	localparam int C_RX_SQ       = 209715;
	localparam int C_LN_100      = 301806;
	localparam int C_LOG_RX_OFS  = 60946;

	// log2(1 + k/2^LOG_TABLE_BITS) in Q16 by repeated squaring of the mantissa
	function automatic lrom_t build_log_rom();
		lrom_t       rom;
		logic [63:0] y;
		logic [19:0] r;
		logic [20:0] t;
		for (int k = 0; k < LOG_ROM_DEPTH; k++) begin
			y = (64'd1 << 30) + (64'(k) << (30 - LOG_TABLE_BITS));
			r = '0;
			for (int i = 0; i < 20; i++) begin
				y = (y * y) >> 30;
				r = r << 1;
				if (y >= (64'd1 << 31)) begin
					r[0] = 1'b1;
					y = y >> 1;
				end
			end
			t = {1'b0, r} + 21'd8;
			rom[k] = t[19:4];
		end
		return rom;
	endfunction

	localparam lrom_t LOG_ROM = build_log_rom();

	// priority encode and normalize, zero behaves as one
	function automatic lgix_t lead_norm(input logic [31:0] x);
		lgix_t       res;
		logic [31:0] xn;
		logic [4:0]  e;
		e = '0;
		for (int b = 0; b < 32; b++) begin
			if (x[b]) e = 5'(b);
		end
		xn = x << (5'd31 - e);
		res.e = e;
		res.k = xn[30 -: LOG_TABLE_BITS];
		return res;
	endfunction

	// drop the Q30 factor, round to nearest (value is never negative)
	function automatic lg_t log_round(input lgp_t p);
		lgp_t t;
		t = p + (LGP_W'(1) << 29);
		return lg_t'(t[LGP_W-1:30]);
	endfunction

	// Q32 back to Q16, half away from zero
	function automatic rv_t rnd_q16(input pw_t v);
		pw_t t;
		t = v + (pw_t'(1) <<< 15) - pw_t'(v[PW_W-1]);
		t = t >>> 16;
		return t[RV_W-1:0];
	endfunction

endpackage

[rtl/plrx_if.sv]
// valid/ready channel interfaces for the path loss engine
// link carries transmit power and distance, result carries received power and flags
// no dependencies
interface plrx_link_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] tx_power;
	logic [23:0]        distance_m;

	modport source (output valid, output tx_power, output distance_m, input ready);
	modport sink   (input valid, input tx_power, input distance_m, output ready);
endinterface

interface plrx_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] rx_power;
	logic               bad_distance;
	logic               saturated;

	modport source (output valid, output rx_power, output bad_distance, output saturated,
		input ready);
	modport sink   (input valid, input rx_power, input bad_distance, input saturated,
		output ready);
endinterface

[rtl/path_loss_rx_power.sv]
// path loss engine: received power = transmit power - macro-cell path loss
// depends on plrx_pkg and the channel interfaces in plrx_if.sv
//
// channel  dir  payload                                   handshake
// link     in   tx_power (Q8.8 dBm), distance_m (metres)  valid/ready
// result   out  rx_power (Q8.8 dBm), bad_distance, sat    valid/ready
// cfg      in   cfg_index, cfg_wdata                      cfg_we, no wait
//
// ten register stages, one transaction per cycle while the result side takes them
// stages: encode, log2 rom, log base multiply, round, term multiply, round,
// second multiply, round and sum, subtract, round and clamp
// arst_n clears the stage valid bits and loads the register defaults
// a stall holds full stages with no bubble ahead; empty stages fill, so bubbles are squeezed out
module path_loss_rx_power (
	input  logic                               clk,
	input  logic                               arst_n,
	plrx_link_if.sink                          link,
	plrx_result_if.source                      result,
	input  logic                               cfg_we,
	input  logic [plrx_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [plrx_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import plrx_pkg::*;

	// configuration registers
	logic [15:0] frequency_q;
	logic [15:0] tx_height_q;
	logic [15:0] rx_height_q;
	logic [1:0]  environment_q;

	// stage control
	logic [N_STAGES-1:0] valid_q;
	logic [N_STAGES-1:0] load;

	// side band carried down the pipe
	logic signed [15:0] tx_pipe_q  [N_STAGES-2];
	logic               bad_pipe_q [N_STAGES];

	// stage data
	logic [31:0] dist_in;
	lgix_t ix_d_s1, ix_f_s1, ix_t_s1, ix_r_s1;
	lg2_t  l2_d_s2, l2_f_s2, l2_t_s2, l2_r_s2;
	lgp_t  pd_s3, pf_s3, pt_s3, pr_s3, pn_s3;
	lg_t   ld_s4, lf_s4, ltx_s4, lr_s4, lnr_s4;
	pw_t   a1_sel;
	rv_t   a0_sel;
	pw_t   a1ld_s5, tl_s5, lr2_s5, lf2_s5, gf1_s5;
	rv_t   ln12_s5, a0_s5;
	rv_t   a1ld_s6, tl_s6, lr2_s6, lf2_s6, gf1_s6;
	acc_t  base_s6;
	pw_t   tlc_s7, lr2c_s7, lf2c_s7;
	acc_t  pre_s7;
	acc_t  loss_s8;
	acc_t  diff_s9;
	acc_t  rnd_pow;
	logic signed [15:0] rx_s10;
	logic               sat_s10;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frequency_q   <= FREQUENCY_RESET;
			tx_height_q   <= TX_HEIGHT_RESET;
			rx_height_q   <= RX_HEIGHT_RESET;
			environment_q <= ENV_URBAN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FREQUENCY:   frequency_q   <= cfg_wdata[15:0];
				REG_TX_HEIGHT:   tx_height_q   <= cfg_wdata[15:0];
				REG_RX_HEIGHT:   rx_height_q   <= cfg_wdata[15:0];
				REG_ENVIRONMENT: environment_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the next one moves on
	always_comb begin
		load[N_STAGES-1] = !valid_q[N_STAGES-1] || result.ready;
		for (int i = N_STAGES - 2; i >= 0; i--) begin
			load[i] = !valid_q[i] || load[i+1];
		end
	end

	assign link.ready = load[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) valid_q[0] <= link.valid;
			for (int i = 1; i < N_STAGES; i++) begin
				if (load[i]) valid_q[i] <= valid_q[i-1];
			end
		end
	end

	// transmit power and zero-distance flag ride along
	assign dist_in = 32'(link.distance_m[DISTANCE_BITS-1:0]);

	always_ff @(posedge clk) begin
		if (load[0]) begin
			tx_pipe_q[0]  <= link.tx_power;
			bad_pipe_q[0] <= (dist_in == '0);
		end
		for (int i = 1; i < N_STAGES - 2; i++) begin
			if (load[i]) tx_pipe_q[i] <= tx_pipe_q[i-1];
		end
		for (int i = 1; i < N_STAGES; i++) begin
			if (load[i]) bad_pipe_q[i] <= bad_pipe_q[i-1];
		end
	end

	// s1: leading one and table index for the four logs
	always_ff @(posedge clk) begin
		if (load[0]) begin
			ix_d_s1 <= lead_norm(dist_in);
			ix_f_s1 <= lead_norm(32'(frequency_q));
			ix_t_s1 <= lead_norm(32'(tx_height_q));
			ix_r_s1 <= lead_norm(32'(rx_height_q));
		end
	end

	// s2: log2 = exponent plus rom fraction
	always_ff @(posedge clk) begin
		if (load[1]) begin
			l2_d_s2 <= {ix_d_s1.e, LOG_ROM[ix_d_s1.k]};
			l2_f_s2 <= {ix_f_s1.e, LOG_ROM[ix_f_s1.k]};
			l2_t_s2 <= {ix_t_s1.e, LOG_ROM[ix_t_s1.k]};
			l2_r_s2 <= {ix_r_s1.e, LOG_ROM[ix_r_s1.k]};
		end
	end

	// s3: change of log base
	always_ff @(posedge clk) begin
		if (load[2]) begin
			pd_s3 <= LGP_W'(l2_d_s2) * LGP_W'(LOG10_2_Q30);
			pf_s3 <= LGP_W'(l2_f_s2) * LGP_W'(LOG10_2_Q30);
			pt_s3 <= LGP_W'(l2_t_s2) * LGP_W'(LOG10_2_Q30);
			pr_s3 <= LGP_W'(l2_r_s2) * LGP_W'(LOG10_2_Q30);
			pn_s3 <= LGP_W'(l2_r_s2) * LGP_W'(LN_2_Q30);
		end
	end

	// s4: round to Q16 and apply unit offsets (km, metres, 11.75 factor, 100 for ln)
	always_ff @(posedge clk) begin
		if (load[3]) begin
			ld_s4  <= log_round(pd_s3) - lg_t'(3 * Q16_ONE);
			lf_s4  <= log_round(pf_s3);
			ltx_s4 <= log_round(pt_s3) - lg_t'(2 * Q16_ONE);
			lr_s4  <= log_round(pr_s3) - lg_t'(C_LOG_RX_OFS);
			lnr_s4 <= log_round(pn_s3) - lg_t'(C_LN_100);
		end
	end

	// terrain coefficients
	always_comb begin
		case (environment_q)
			ENV_URBAN: begin
				a0_sel = rv_t'(C_A0_URBAN);
				a1_sel = pw_t'(C_A1_URBAN);
			end
			ENV_SUBURBAN: begin
				a0_sel = rv_t'(C_A0_SUBURBAN);
				a1_sel = pw_t'(C_A1_SUBURBAN);
			end
			default: begin
				a0_sel = rv_t'(C_A0_RURAL);
				a1_sel = pw_t'(C_A1_RURAL);
			end
		endcase
	end

	// s5: first products
	always_ff @(posedge clk) begin
		if (load[4]) begin
			a1ld_s5 <= a1_sel * pw_t'(ld_s4);
			tl_s5   <= pw_t'(ltx_s4) * pw_t'(ld_s4);
			lr2_s5  <= pw_t'(lr_s4) * pw_t'(lr_s4);
			lf2_s5  <= pw_t'(lf_s4) * pw_t'(lf_s4);
			gf1_s5  <= pw_t'(C_FREQ_LIN) * pw_t'(lf_s4);
			ln12_s5 <= (rv_t'(lnr_s4) <<< 3) + (rv_t'(lnr_s4) <<< 2);
			a0_s5   <= a0_sel;
		end
	end

	// s6: round first products, start the loss sum
	always_ff @(posedge clk) begin
		if (load[5]) begin
			a1ld_s6 <= rnd_q16(a1ld_s5);
			tl_s6   <= rnd_q16(tl_s5);
			lr2_s6  <= rnd_q16(lr2_s5);
			lf2_s6  <= rnd_q16(lf2_s5);
			gf1_s6  <= rnd_q16(gf1_s5);
			base_s6 <= acc_t'(a0_s5) + acc_t'(ln12_s5);
		end
	end

	// s7: second products, add the finished terms
	always_ff @(posedge clk) begin
		if (load[6]) begin
			tlc_s7  <= pw_t'(tl_s6) * pw_t'(C_CROSS);
			lr2c_s7 <= pw_t'(lr2_s6) * pw_t'(C_RX_SQ);
			lf2c_s7 <= pw_t'(lf2_s6) * pw_t'(C_FREQ_SQ);
			pre_s7  <= base_s6 + acc_t'(a1ld_s6) + acc_t'(gf1_s6);
		end
	end

	// s8: total loss
	always_ff @(posedge clk) begin
		if (load[7]) begin
			loss_s8 <= pre_s7 + acc_t'(rnd_q16(tlc_s7))
				- acc_t'(rnd_q16(lr2c_s7)) - acc_t'(rnd_q16(lf2c_s7));
		end
	end

	// s9: received power in Q16
	always_ff @(posedge clk) begin
		if (load[8]) begin
			diff_s9 <= (acc_t'(tx_pipe_q[N_STAGES-3]) <<< 8) - loss_s8;
		end
	end

	// s10: round to Q8.8, clamp, zero distance gives fixed values
	assign rnd_pow = (diff_s9 + acc_t'(128) - acc_t'(diff_s9[ACC_W-1])) >>> 8;

	always_ff @(posedge clk) begin
		if (load[9]) begin
			if (bad_pipe_q[N_STAGES-2]) begin
				rx_s10  <= '0;
				sat_s10 <= 1'b0;
			end else if (rnd_pow > acc_t'(32767)) begin
				rx_s10  <= 16'sh7fff;
				sat_s10 <= 1'b1;
			end else if (rnd_pow < acc_t'(-32768)) begin
				rx_s10  <= 16'sh8000;
				sat_s10 <= 1'b1;
			end else begin
				rx_s10  <= rnd_pow[15:0];
				sat_s10 <= 1'b0;
			end
		end
	end

	assign result.valid        = valid_q[N_STAGES-1];
	assign result.rx_power     = rx_s10;
	assign result.bad_distance = bad_pipe_q[N_STAGES-1];
	assign result.saturated    = sat_s10;

endmodule

[rtl/plrx_checker.sv]
// port-level checks for the path loss engine, bound to path_loss_rx_power
// depends only on the top-level ports
module plrx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        link_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] rx_power,
	input logic        bad_distance,
	input logic        saturated
);

	// a result is held until taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transaction");

	// zero distance gives the fixed result
	a_bad_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_distance |-> rx_power == 16'h0000 && !saturated)
		else $error("zero distance result not fixed");

	// clamped results sit on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> rx_power == 16'h7fff || rx_power == 16'h8000)
		else $error("saturated flag without rail value");

	// a draining output never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> link_ready)
		else $error("input blocked while output drains");

endmodule

bind path_loss_rx_power plrx_checker u_plrx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.link_ready   (link.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.rx_power     (result.rx_power),
	.bad_distance (result.bad_distance),
	.saturated    (result.saturated)
);

[dv/testbench.sv]
`timescale 1ns / 100ps
// testbench for path_loss_rx_power: received power prediction checked against the result channel
// depends on plrx_pkg, the channel interfaces in plrx_if.sv and the path_loss_rx_power rtl
module testbench;
	import plrx_pkg::*;

	localparam int     TAB_BITS        = LOG_TABLE_BITS;
	localparam int     TAB_SIZE        = 1 << TAB_BITS;
	localparam longint Q16             = 65536;
	localparam longint LOG10_OF_2_Q30  = 323228497;
	localparam longint LN_OF_2_Q30     = 744261118;
	localparam longint URBAN_A0        = 2372403;
	localparam longint URBAN_A1        = 1979187;
	localparam longint SUBURBAN_A0     = 2831155;
	localparam longint SUBURBAN_A1     = 4517404;
	localparam longint RURAL_A0        = 3011379;
	localparam longint RURAL_A1        = 6592922;
	localparam longint FREQ_LIN_Q16    = 2915697;
	localparam longint FREQ_SQ_Q16     = 313262;
	localparam longint CROSS_Q16       = 6554;
	localparam longint RXH_SQ_Q16      = 209715;
	localparam longint LN_100_Q16      = 301806;
	localparam longint LOG_REL_RXH_Q16 = -60946;

	localparam int N_PHASES        = 10;
	localparam int ITEMS_PER_PHASE = 55;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_SLACK     = 16;
	localparam int QUIET_LIMIT     = 3000;

	typedef struct packed {
		logic signed [15:0] rx_power;
		logic               bad_distance;
		logic               saturated;
	} rx_result_t;

	// expected received power per accepted link transaction
	class path_loss_scoreboard;
		logic [15:0] freq_mhz;
		logic [15:0] tx_height;
		logic [15:0] rx_height;
		logic [1:0]  env;
		int          frac_q16 [TAB_SIZE];
		rx_result_t  rx_expected_q [$];
		int          mismatches;

		function new();
			logic [63:0] y;
			logic [19:0] r;
			freq_mhz   = 16'd2000;
			tx_height  = 16'd5000;
			rx_height  = 16'd300;
			env        = ENV_URBAN;
			mismatches = 0;
			// fraction table: log2 of the normalized mantissa by repeated squaring
			for (int k = 0; k < TAB_SIZE; k++) begin
				y = (64'd1 << 30) + (64'(k) << (30 - TAB_BITS));
				r = '0;
				for (int i = 0; i < 20; i++) begin
					y = (y * y) >> 30;
					r = r << 1;
					if (y >= (64'd1 << 31)) begin
						r[0] = 1'b1;
						y = y >> 1;
					end
				end
				frac_q16[k] = (int'(r) + 8) >> 4;
			end
		endfunction

		function void set_reg(reg_index_t idx, logic [15:0] v);
			case (idx)
				REG_FREQUENCY:   freq_mhz  = v;
				REG_TX_HEIGHT:   tx_height = v;
				REG_RX_HEIGHT:   rx_height = v;
				REG_ENVIRONMENT: env       = v[1:0];
				default: ;
			endcase
		endfunction

		// right shift with rounding half away from zero
		function longint round_shift(longint v, int s);
			longint half;
			half = longint'(1) << (s - 1);
			if (v >= 0)
				return (v + half) >>> s;
			return -((-v + half) >>> s);
		endfunction

		function longint mul_q16(longint a, longint b);
			return round_shift(a * b, 16);
		endfunction

		// zero counts as one
		function longint log2_q16(logic [31:0] x);
			int     e;
			longint m;
			if (x == 0)
				x = 1;
			e = 31;
			while (!x[e])
				e--;
			if (e >= TAB_BITS)
				m = (x >> (e - TAB_BITS)) & (TAB_SIZE - 1);
			else
				m = (x << (TAB_BITS - e)) & (TAB_SIZE - 1);
			return longint'(e) * Q16 + frac_q16[m];
		endfunction

		function longint log10_q16(logic [31:0] x);
			return round_shift(log2_q16(x) * LOG10_OF_2_Q30, 30);
		endfunction

		function longint ln_q16(logic [31:0] x);
			return round_shift(log2_q16(x) * LN_OF_2_Q30, 30);
		endfunction

		function rx_result_t predict_rx_power(logic signed [15:0] tx, logic [23:0] dist_m);
			rx_result_t res;
			longint     a0, a1, lf, gf, ld, ltx, lr, loss, rx;
			res.bad_distance = 1'b0;
			res.saturated    = 1'b0;
			// zero distance gives a fixed flagged result
			if (dist_m == 0) begin
				res.rx_power     = '0;
				res.bad_distance = 1'b1;
				return res;
			end
			case (env)
				ENV_URBAN: begin
					a0 = URBAN_A0;
					a1 = URBAN_A1;
				end
				ENV_SUBURBAN: begin
					a0 = SUBURBAN_A0;
					a1 = SUBURBAN_A1;
				end
				default: begin
					a0 = RURAL_A0;
					a1 = RURAL_A1;
				end
			endcase
			lf  = log10_q16(freq_mhz);
			gf  = mul_q16(FREQ_LIN_Q16, lf) - mul_q16(FREQ_SQ_Q16, mul_q16(lf, lf));
			ld  = log10_q16(dist_m) - 3 * Q16;
			ltx = log10_q16(tx_height) - 2 * Q16;
			lr  = log10_q16(rx_height) + LOG_REL_RXH_Q16;
			loss = a0 + mul_q16(a1, ld)
				+ 12 * (ln_q16(rx_height) - LN_100_Q16)
				+ mul_q16(CROSS_Q16, mul_q16(ltx, ld))
				- mul_q16(RXH_SQ_Q16, mul_q16(lr, lr))
				+ gf;
			rx = round_shift(longint'(tx) * 256 - loss, 8);
			if (rx > 32767) begin
				rx = 32767;
				res.saturated = 1'b1;
			end else if (rx < -32768) begin
				rx = -32768;
				res.saturated = 1'b1;
			end
			res.rx_power = 16'(rx);
			return res;
		endfunction

		function void note_input(logic signed [15:0] tx, logic [23:0] dist_m);
			rx_expected_q.push_back(predict_rx_power(tx, dist_m));
		endfunction

		function void report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void check_result(logic signed [15:0] rx, logic bad, logic sat);
			rx_result_t want;
			if (rx_expected_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: rx_power %0d", rx));
				return;
			end
			want = rx_expected_q.pop_front();
			if (rx !== want.rx_power || bad !== want.bad_distance || sat !== want.saturated)
				report_mismatch($sformatf(
					{"mismatch: rx_power exp %0d got %0d, ",
					"bad_distance exp %0b got %0b, saturated exp %0b got %0b"},
					want.rx_power, rx, want.bad_distance, bad, want.saturated, sat));
		endfunction

		function int pending();
			return rx_expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	plrx_link_if   link();
	plrx_result_if result();

	path_loss_scoreboard sb = new();

	int src_idle_pct    = 0;
	int sink_stall_pct  = 0;
	int holds_requested = 0;

	path_loss_rx_power dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.link      (link),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// drive one link transaction, with a random gap ahead of it
	task automatic send_link(input logic signed [15:0] tx, input logic [23:0] dist_m);
		if ($urandom_range(99) < src_idle_pct) begin
			link.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		link.valid      <= 1'b1;
		link.tx_power   <= tx;
		link.distance_m <= dist_m;
		do @(posedge clk); while (!link.ready);
		sb.note_input(tx, dist_m);
	endtask

	// stop offering and wait until the pipeline is empty
	task automatic wait_drained();
		link.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// write all four registers on back-to-back cycles
	task automatic load_config(input logic [15:0] freq, input logic [15:0] tx_h,
		input logic [15:0] rx_h, input logic [15:0] env_word);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FREQUENCY;
		cfg_wdata <= freq;
		@(posedge clk);
		cfg_index <= REG_TX_HEIGHT;
		cfg_wdata <= tx_h;
		@(posedge clk);
		cfg_index <= REG_RX_HEIGHT;
		cfg_wdata <= rx_h;
		@(posedge clk);
		cfg_index <= REG_ENVIRONMENT;
		cfg_wdata <= env_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_FREQUENCY, freq);
		sb.set_reg(REG_TX_HEIGHT, tx_h);
		sb.set_reg(REG_RX_HEIGHT, rx_h);
		sb.set_reg(REG_ENVIRONMENT, env_word);
	endtask

	// register value: extremes now and then, otherwise spread over the decades
	function automatic logic [15:0] pick_reg_value();
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			default: return 16'($urandom_range(1, 65535) >> $urandom_range(0, 15));
		endcase
	endfunction

	// result side: random stalls, long hold-offs on request, checks on every transaction
	initial begin
		int hold_left;
		int holds_served;
		hold_left    = 0;
		holds_served = 0;
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result.valid && result.ready)
				sb.check_result(result.rx_power, result.bad_distance, result.saturated);
			if (holds_served != holds_requested) begin
				holds_served = holds_requested;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else
				result.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// watchdog on cycles with no transaction on either channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (link.valid && link.ready) || (result.valid && result.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// stimulus
	initial begin
		logic signed [15:0] tx;
		logic [23:0]        dist_m;
		logic [15:0]        env_word;

		arst_n          = 1'b0;
		link.valid      = 1'b0;
		link.tx_power   = '0;
		link.distance_m = '0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed at reset settings: zero distance, field extremes, table index edges
		send_link(16'sd0, 24'd0);
		send_link(16'sh7FFF, 24'd0);
		send_link(16'sh8000, 24'd0);
		send_link(16'sd0, 24'd1);
		send_link(16'sh7FFF, 24'd1);
		send_link(16'sh8000, 24'd1);
		send_link(16'sd0, 24'hFFFFFF);
		send_link(16'sh8000, 24'hFFFFFF);
		send_link(16'sh7FFF, 24'hFFFFFF);
		send_link(16'sh5555, 24'h555555);
		send_link(16'shAAAA, 24'hAAAAAA);
		send_link(16'sd256, 24'd255);
		send_link(-16'sd7680, 24'd256);
		send_link(16'sd512, 24'd257);
		send_link(16'sd0, 24'd1000);

		// rural, lowest frequency and rx height: high-side clamp
		wait_drained();
		load_config(16'd1, 16'hFFFF, 16'd1, 16'(ENV_RURAL));
		send_link(16'sh7FFF, 24'd1);
		send_link(16'sh8000, 24'hFFFFFF);
		send_link(16'sd0, 24'd3);

		// zero registers count as one, unused terrain code with upper data bits set
		wait_drained();
		load_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
		send_link(16'sh8000, 24'hFFFFFF);
		send_link(16'sh7FFF, 24'd1);
		send_link(16'sd100, 24'd0);

		// suburban, highest frequency and rx height, lowest tx height
		wait_drained();
		load_config(16'hFFFF, 16'd1, 16'hFFFF, 16'(ENV_SUBURBAN));
		send_link(16'sh8000, 24'hFFFFFF);
		send_link(16'sh7FFF, 24'd1);
		send_link(16'sd0, 24'd12345);

		// random phases over settings and idle patterns
		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			if (p == 0)
				load_config(16'd2000, 16'd5000, 16'd300, 16'(ENV_URBAN));
			else begin
				env_word      = 16'($urandom);
				env_word[1:0] = 2'($urandom_range(0, 3));
				load_config(pick_reg_value(), pick_reg_value(), pick_reg_value(), env_word);
			end
			case (p % 4)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 63;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 63;
				end
				default: begin
					src_idle_pct   = 33;
					sink_stall_pct = 33;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long result hold-off while the link keeps offering
				if (p % 4 == 0 && n == 12)
					holds_requested++;
				case ($urandom_range(19))
					0:       tx = 16'sh8000;
					1:       tx = 16'sh7FFF;
					default: tx = 16'($urandom);
				endcase
				case ($urandom_range(19))
					0:                   dist_m = 24'd0;
					1:                   dist_m = 24'd1;
					2:                   dist_m = 24'hFFFFFF;
					3, 4, 5, 6, 7, 8, 9: dist_m = 24'($urandom);
					default:             dist_m = 24'($urandom) >> $urandom_range(0, 23);
				endcase
				send_link(tx, dist_m);
			end
		end

		wait_drained();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
